### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge while reset is released.
`define RMTE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks a property on every clock edge, during reset as well.
`define RMTE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### src/rmte_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles package
// Turn-angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rmte_pkg;

    // Internal angles are unsigned binary angles, 2^32 per turn.
    localparam int TURN_BITS = 32;
    typedef logic [TURN_BITS-1:0] t_turn;

    localparam t_turn HALF_TURN    = 32'h8000_0000;
    localparam t_turn QUARTER_TURN = 32'h4000_0000;

    // Inverse CORDIC gain in Q31.
    localparam logic [63:0] GAIN_INV_Q31 = 64'd1304065749;

    // atan(2^-i) as a turn angle, rounded.
    function automatic t_turn atan_entry(input int idx);
        t_turn v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### src/rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles
// ZYX yaw, pitch and roll from a Q2.14 rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// The block accepts one matrix per clock cycle unless o_stall is high and
// returns yaw, pitch and roll as binary angles (the most negative code is
// -pi). It chains a vectoring CORDIC for yaw, a rotating CORDIC for the
// cosine and sine of the rounded yaw, one multiply stage, then two vectoring
// CORDICs side by side for pitch and roll, each CORDIC using one register
// stage per iteration plus its pre-rotation (the rotating one also a final
// fold-undo register). Output stall freezes the whole pipeline only while a
// finished result is held; bubbles keep filling otherwise.
module rotation_matrix_to_euler_angles #(
    parameter int MATRIX_FRAC_BITS = 14,
    parameter int ANGLE_BITS       = 16,
    parameter int CORDIC_STAGES    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_roll_angle
);
    import rmte_pkg::*;

    localparam int F       = MATRIX_FRAC_BITS;
    localparam int CW      = F + 3;
    localparam int PW      = 16 + CW;
    localparam int W       = F + 22;
    localparam int SH      = TURN_BITS - ANGLE_BITS;
    localparam logic [TURN_BITS:0] ROUND_HALF =
        (SH == 0) ? '0 : ((TURN_BITS+1)'(1) << (SH - 1));
    localparam int OB      = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int VEC_LAT = CORDIC_STAGES + 1;
    localparam int ROT_LAT = CORDIC_STAGES + 2;

    logic en;
    logic r_out_valid;

    // The pipeline advances unless a held result is being stalled.
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Yaw from the first column.
    logic               yaw_valid;
    t_turn              yaw_z;
    logic [ANGLE_BITS-1:0] yaw_code;
    logic [TURN_BITS:0]    yaw_sum;
    t_turn              yaw_turn;

    rmte_vec_cordic #(.WIDTH(W), .STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_y     (W'(i_m10) <<< F),
        .i_x     (W'(i_m00) <<< F),
        .o_valid (yaw_valid),
        .o_z     (yaw_z)
    );

    // Round yaw to the output resolution; cos/sin use the rounded angle.
    assign yaw_sum  = {1'b0, yaw_z} + ROUND_HALF;
    assign yaw_code = yaw_sum[SH +: ANGLE_BITS];
    assign yaw_turn = TURN_BITS'(yaw_code) << SH;

    logic               cs_valid;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;

    rmte_rot_cordic #(.FRAC(F), .STAGES(CORDIC_STAGES)) u_cossin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (yaw_valid),
        .i_z     (yaw_turn),
        .o_valid (cs_valid),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    // Matrix entries travel alongside yaw and cos/sin.
    logic [7*16-1:0] mat_d;
    logic signed [15:0] d00, d01, d02, d10, d11, d12, d20;

    rmte_delay #(.WIDTH(7*16), .DEPTH(VEC_LAT + ROT_LAT)) u_mat_dly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20}),
        .o_data (mat_d)
    );
    assign {d00, d01, d02, d10, d11, d12, d20} = mat_d;

    // Rounded yaw waits for pitch and roll.
    logic [ANGLE_BITS-1:0] yaw_d;

    rmte_delay #(.WIDTH(ANGLE_BITS), .DEPTH(ROT_LAT + 1 + VEC_LAT)) u_yaw_dly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (yaw_code),
        .o_data (yaw_d)
    );

    // Products for the pitch and roll operands.
    logic               r_prod_valid;
    logic signed [PW-1:0] r_p00c, r_p10s, r_p02s, r_p12c, r_p01s, r_p11c;
    logic signed [15:0] r_m20;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (en) begin
            r_prod_valid <= cs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p00c <= PW'(d00) * PW'(cos_v);
            r_p10s <= PW'(d10) * PW'(sin_v);
            r_p02s <= PW'(d02) * PW'(sin_v);
            r_p12c <= PW'(d12) * PW'(cos_v);
            r_p01s <= PW'(d01) * PW'(sin_v);
            r_p11c <= PW'(d11) * PW'(cos_v);
            r_m20  <= d20;
        end
    end

    logic signed [W-1:0] pitch_y, pitch_x, roll_y, roll_x;

    assign pitch_y = -(W'(r_m20) <<< F);
    assign pitch_x = W'(r_p00c) + W'(r_p10s);
    assign roll_y  = W'(r_p02s) - W'(r_p12c);
    assign roll_x  = W'(r_p11c) - W'(r_p01s);

    // Pitch and roll in parallel.
    logic  pitch_valid, roll_valid;
    t_turn pitch_z, roll_z;

    rmte_vec_cordic #(.WIDTH(W), .STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_prod_valid),
        .i_y     (pitch_y),
        .i_x     (pitch_x),
        .o_valid (pitch_valid),
        .o_z     (pitch_z)
    );

    rmte_vec_cordic #(.WIDTH(W), .STAGES(CORDIC_STAGES)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_prod_valid),
        .i_y     (roll_y),
        .i_x     (roll_x),
        .o_valid (roll_valid),
        .o_z     (roll_z)
    );

    logic [TURN_BITS:0]    pitch_sum, roll_sum;
    logic [ANGLE_BITS-1:0] pitch_code, roll_code;

    assign pitch_sum  = {1'b0, pitch_z} + ROUND_HALF;
    assign roll_sum   = {1'b0, roll_z} + ROUND_HALF;
    assign pitch_code = pitch_sum[SH +: ANGLE_BITS];
    assign roll_code  = roll_sum[SH +: ANGLE_BITS];

    // Output register holds the transaction until it is taken.
    logic [15:0] r_yaw, r_pitch, r_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= pitch_valid && roll_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw   <= 16'(yaw_d[OB-1:0]);
            r_pitch <= 16'(pitch_code[OB-1:0]);
            r_roll  <= 16'(roll_code[OB-1:0]);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_yaw_angle   = r_yaw;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;

endmodule

### src/rmte_delay.sv
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries side data alongside the CORDIC stages, advancing on enable.
// ----------------------------------------------------------------------------
module rmte_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [0:DEPTH-1];

    // Shift one place on every pipeline advance.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

### src/rmte_vec_cordic.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Pipelined atan2 with one register stage per iteration and a pre-rotation.
// ----------------------------------------------------------------------------
module rmte_vec_cordic #(
    parameter int WIDTH  = 36,
    parameter int STAGES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [WIDTH-1:0]  i_y,
    input  logic signed [WIDTH-1:0]  i_x,
    output logic                     o_valid,
    output rmte_pkg::t_turn          o_z
);
    import rmte_pkg::*;

    logic              r_valid [0:STAGES];
    logic              r_zero  [0:STAGES];
    logic signed [WIDTH-1:0] r_x [0:STAGES];
    logic signed [WIDTH-1:0] r_y [0:STAGES];
    t_turn             r_z     [0:STAGES];

    // Pre-rotation: fold the left half plane onto the right one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    // One micro-rotation per stage, driving y toward zero.
    for (genvar j = 1; j <= STAGES; j++) begin : g_stage
        localparam t_turn ATAN = atan_entry(j - 1);
        logic y_pos;
        assign y_pos = !r_y[j-1][WIDTH-1] && (r_y[j-1] != '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= r_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[j] <= r_zero[j-1];
                if (y_pos) begin
                    r_x[j] <= r_x[j-1] + (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] - (r_x[j-1] >>> (j - 1));
                    r_z[j] <= r_z[j-1] + ATAN;
                end else begin
                    r_x[j] <= r_x[j-1] - (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] + (r_x[j-1] >>> (j - 1));
                    r_z[j] <= r_z[j-1] - ATAN;
                end
            end
        end
    end

    // A zero vector has angle zero.
    assign o_valid = r_valid[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

### src/rmte_rot_cordic.sv
// ----------------------------------------------------------------------------
// Rotating CORDIC
// Pipelined cosine and sine of a turn angle, gain compensated.
// ----------------------------------------------------------------------------
module rmte_rot_cordic #(
    parameter int FRAC   = 14,
    parameter int STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  rmte_pkg::t_turn         i_z,
    output logic                    o_valid,
    output logic signed [FRAC+2:0]  o_cos,
    output logic signed [FRAC+2:0]  o_sin
);
    import rmte_pkg::*;

    localparam int CW = FRAC + 3;
    localparam logic [63:0] X_INIT_WIDE =
        (GAIN_INV_Q31 + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    localparam logic signed [CW-1:0] X_INIT = CW'(X_INIT_WIDE);

    logic              r_valid [0:STAGES+1];
    logic              r_flip  [0:STAGES];
    logic signed [CW-1:0] r_x  [0:STAGES];
    logic signed [CW-1:0] r_y  [0:STAGES];
    t_turn             r_z     [0:STAGES];
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;
    t_turn             z_shift;

    assign z_shift = i_z + QUARTER_TURN;

    // Bring the angle into the right half plane; remember to negate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= X_INIT;
            r_y[0] <= '0;
            if (z_shift > HALF_TURN) begin
                r_z[0]    <= i_z + HALF_TURN;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= i_z;
                r_flip[0] <= 1'b0;
            end
        end
    end

    // One micro-rotation per stage, driving z toward zero.
    for (genvar j = 1; j <= STAGES; j++) begin : g_stage
        localparam t_turn ATAN = atan_entry(j - 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= r_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[j] <= r_flip[j-1];
                if (!r_z[j-1][TURN_BITS-1]) begin
                    r_x[j] <= r_x[j-1] - (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] + (r_x[j-1] >>> (j - 1));
                    r_z[j] <= r_z[j-1] - ATAN;
                end else begin
                    r_x[j] <= r_x[j-1] + (r_y[j-1] >>> (j - 1));
                    r_y[j] <= r_y[j-1] - (r_x[j-1] >>> (j - 1));
                    r_z[j] <= r_z[j-1] + ATAN;
                end
            end
        end
    end

    // Undo the half-turn fold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[STAGES+1] <= 1'b0;
        end else if (i_en) begin
            r_valid[STAGES+1] <= r_valid[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
            r_sin <= r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        end
    end

    assign o_valid = r_valid[STAGES+1];
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

### src/rmte_checker.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles checker
// Port-level assertions on handshake and pipeline behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [15:0] i_m00,
    input logic signed [15:0] i_m01,
    input logic signed [15:0] i_m02,
    input logic signed [15:0] i_m10,
    input logic signed [15:0] i_m11,
    input logic signed [15:0] i_m12,
    input logic signed [15:0] i_m20,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_yaw_angle,
    input logic signed [15:0] o_pitch_angle,
    input logic signed [15:0] o_roll_angle
);

    // All three angles of the offered result, side by side.
    logic [47:0] out_angles;

    assign out_angles = {o_yaw_angle, o_pitch_angle, o_roll_angle};

    // A stalled result transaction stays offered.
    `RMTE_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)

    // A stalled result keeps its angles.
    `RMTE_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(out_angles))

    // Input is held back only while a finished result is blocked.
    `RMTE_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall == (o_valid && i_stall))

    // Reset empties the pipeline.
    `RMTE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind rotation_matrix_to_euler_angles rmte_checker u_rmte_checker (.*);

### verif/tb_rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles testbench
// Drives Q2.14 matrices through the valid/stall input channel and checks
// every yaw, pitch and roll transaction against a fixed-point CORDIC
// predictor. A directed table of corner matrices comes first, followed by
// random rotations built from random angles and raw random entries.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_angles;
    import rmte_pkg::*;

    localparam int FRAC_BITS  = 14;
    localparam int ANG_BITS   = 16;
    localparam int STAGES     = 16;
    localparam int LATENCY    = 3 * STAGES + 6;
    localparam int NUM_RANDOM = 700;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20;
    } t_matrix;

    typedef struct {
        logic [15:0] yaw, pitch, roll;
    } t_angles;

    typedef struct {
        t_matrix mat;
        logic    typed;  // expected angles given in the row
        t_angles ang;
    } t_vector;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_yaw_angle, o_pitch_angle, o_roll_angle;

    t_angles angle_queue[$];
    int      error_count;
    int      cycle_count;
    bit      no_idle;

    rotation_matrix_to_euler_angles DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(i_m00), .i_m01(i_m01), .i_m02(i_m02),
        .i_m10(i_m10), .i_m11(i_m11), .i_m12(i_m12), .i_m20(i_m20),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_yaw_angle(o_yaw_angle), .o_pitch_angle(o_pitch_angle),
        .o_roll_angle(o_roll_angle)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor shift for signed 64-bit values.
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    // Vectoring CORDIC: turn angle of (x, y).
    function automatic t_turn vector_angle(longint y, longint x);
        t_turn  z;
        longint xo;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++) begin
            xo = x;
            if (y > 0) begin
                x = x + floor_shift(y, i);
                y = y - floor_shift(xo, i);
                z = z + atan_entry(i);
            end else begin
                x = x - floor_shift(y, i);
                y = y + floor_shift(xo, i);
                z = z - atan_entry(i);
            end
        end
        return z;
    endfunction

    // Rotating CORDIC: cosine and sine of a turn angle.
    task automatic rotate_unit(input t_turn ang, output longint c, output longint s);
        t_turn       z;
        bit          flip;
        longint      x, y, xo;
        logic [63:0] seed;
        z = ang;
        flip = 1'b0;
        if (t_turn'(z + QUARTER_TURN) > HALF_TURN) begin
            z = z + HALF_TURN;
            flip = 1'b1;
        end
        seed = (GAIN_INV_Q31 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
        x = longint'(seed);
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            xo = x;
            if (!z[31]) begin
                x = x - floor_shift(y, i);
                y = y + floor_shift(xo, i);
                z = z - atan_entry(i);
            end else begin
                x = x + floor_shift(y, i);
                y = y - floor_shift(xo, i);
                z = z + atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Round a turn angle to the output width, half up, wrapping.
    function automatic logic [15:0] round_turn(t_turn z);
        logic [32:0] r;
        r = ({1'b0, z} + (33'd1 << (31 - ANG_BITS))) >> (32 - ANG_BITS);
        return r[15:0];
    endfunction

    // Euler angles expected for one matrix.
    task automatic predict_euler(input t_matrix m, output t_angles a);
        longint scale, c, s;
        longint m00, m01, m02, m10, m11, m12, m20;
        t_turn  yaw_turn;
        scale = longint'(1) << FRAC_BITS;
        m00 = m.m00; m01 = m.m01; m02 = m.m02;
        m10 = m.m10; m11 = m.m11; m12 = m.m12; m20 = m.m20;
        a.yaw = round_turn(vector_angle(m10 * scale, m00 * scale));
        yaw_turn = {a.yaw, 16'h0000};
        rotate_unit(yaw_turn, c, s);
        a.pitch = round_turn(vector_angle(-m20 * scale, m00 * c + m10 * s));
        a.roll = round_turn(vector_angle(m02 * s - m12 * c, -m01 * s + m11 * c));
    endtask

    // Random draw biased to idle with a chance of about 27 in 100.
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 27);
    endfunction

    // Drive one matrix and hold it until the block accepts it.
    task automatic send_matrix(input t_matrix m, input logic typed, input t_angles given);
        t_angles a;
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        predict_euler(m, a);
        if (typed && (a.yaw != given.yaw || a.pitch != given.pitch || a.roll != given.roll))
            $display("%0t: table row disagrees with predictor %h %h %h", $time,
                     given.yaw, given.pitch, given.roll);
        if (typed) a = given;
        i_valid <= 1'b1;
        i_m00 <= m.m00; i_m01 <= m.m01; i_m02 <= m.m02;
        i_m10 <= m.m10; i_m11 <= m.m11; i_m12 <= m.m12; i_m20 <= m.m20;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        angle_queue = {angle_queue, a};
        @(negedge i_clk);
    endtask

    // Random Q2.14 entry across the full field range.
    function automatic logic signed [15:0] any_entry();
        return $urandom_range(3) == 0 ? 16'($urandom) :
               16'(int'($urandom_range(32768)) - 16384);
    endfunction

    // Rotation built from yaw, pitch, roll in Q2.14.
    function automatic t_matrix rotation_from(real y, real p, real r);
        t_matrix m;
        m.m00 = 16'($rtoi($cos(y) * $cos(p) * 16384.0));
        m.m10 = 16'($rtoi($sin(y) * $cos(p) * 16384.0));
        m.m20 = 16'($rtoi(-$sin(p) * 16384.0));
        m.m01 = 16'($rtoi(($cos(y) * $sin(p) * $sin(r) - $sin(y) * $cos(r)) * 16384.0));
        m.m11 = 16'($rtoi(($sin(y) * $sin(p) * $sin(r) + $cos(y) * $cos(r)) * 16384.0));
        m.m02 = 16'($rtoi(($cos(y) * $sin(p) * $cos(r) + $sin(y) * $sin(r)) * 16384.0));
        m.m12 = 16'($rtoi(($sin(y) * $sin(p) * $cos(r) - $cos(y) * $sin(r)) * 16384.0));
        return m;
    endfunction

    // Output side: random stall and checking of each result transaction.
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= idle_now();
    end

    always @(posedge i_clk) begin
        t_angles exp_ang;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected result %h %h %h", $time,
                         o_yaw_angle, o_pitch_angle, o_roll_angle);
                error_count++;
            end else begin
                exp_ang = angle_queue.pop_front();
                if (o_yaw_angle !== exp_ang.yaw) begin
                    $display("%0t: yaw expected %h actual %h", $time, exp_ang.yaw, o_yaw_angle);
                    error_count++;
                end
                if (o_pitch_angle !== exp_ang.pitch) begin
                    $display("%0t: pitch expected %h actual %h", $time,
                             exp_ang.pitch, o_pitch_angle);
                    error_count++;
                end
                if (o_roll_angle !== exp_ang.roll) begin
                    $display("%0t: roll expected %h actual %h", $time,
                             exp_ang.roll, o_roll_angle);
                    error_count++;
                end
            end
        end
    end

    // Timeout.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed table: identity, axis turns, zero and extreme entries.
    t_vector directed[$];

    function automatic t_vector row(int a, int b, int c, int d, int e, int f, int g,
                                    logic typed, int y, int p, int r);
        t_vector v;
        v.mat = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g)};
        v.typed = typed;
        v.ang = '{16'(y), 16'(p), 16'(r)};
        return v;
    endfunction

    // Append one row to the directed table.
    task automatic append_row(input t_vector v);
        directed = {directed, v};
    endtask

    initial begin
        t_matrix  m;
        t_angles  none;
        real      two_pi;
        int       wait_cycles;
        none = '{16'h0, 16'h0, 16'h0};
        two_pi = 6.283185307179586;
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20} = '0;

        // All-zero matrix gives zero angles since both atan2 operands vanish.
        append_row(row(0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0));
        append_row(row(16384, 0, 0, 0, 16384, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(-16384, 0, 0, 0, -16384, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(0, -16384, 0, 16384, 0, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(0, 16384, 0, -16384, 0, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(0, 0, 16384, 0, 16384, 0, -16384, 1'b0, 0, 0, 0));
        append_row(row(0, 0, -16384, 0, 16384, 0, 16384, 1'b0, 0, 0, 0));
        append_row(row(16384, 0, 0, 0, 0, -16384, 0, 1'b0, 0, 0, 0));
        append_row(row(-16384, 16384, -16384, -16384, 16384, -16384, -16384,
                       1'b0, 0, 0, 0));
        append_row(row(16384, -16384, 16384, 16384, -16384, 16384, 16384,
                       1'b0, 0, 0, 0));
        // Entries beyond one, including the most negative and positive codes.
        append_row(row(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                       1'b0, 0, 0, 0));
        append_row(row(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                       1'b0, 0, 0, 0));
        append_row(row(-32768, 32767, 0, 0, 1, -1, 32767, 1'b0, 0, 0, 0));
        // Yaw near -pi on either side of the negative axis.
        append_row(row(-16384, 0, 0, -1, -16384, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(-16384, 0, 0, 1, -16384, 0, 0, 1'b0, 0, 0, 0));
        append_row(row(1, 2, 3, 0, 5, 6, 7, 1'b0, 0, 0, 0));
        append_row(row(0, 0, 0, 0, 0, 0, 16384, 1'b0, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) send_matrix(directed[k].mat, directed[k].typed, directed[k].ang);

        // Random part: mostly true rotations, some raw entries.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle = (n >= 200 && n < 300);
            if (n == 400) begin
                // Let the pipeline drain completely before sending more.
                i_valid <= 1'b0;
                while (angle_queue.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(4) == 0) begin
                m = '{any_entry(), any_entry(), any_entry(), any_entry(),
                      any_entry(), any_entry(), any_entry()};
            end else begin
                m = rotation_from(($urandom_range(65535) / 65536.0 - 0.5) * two_pi,
                                  ($urandom_range(65535) / 65536.0 - 0.5) * two_pi / 2.0,
                                  ($urandom_range(65535) / 65536.0 - 0.5) * two_pi);
            end
            send_matrix(m, 1'b0, none);
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        // Drain the remaining results, then watch for stray ones.
        while (angle_queue.size() != 0) @(negedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY) begin
            @(negedge i_clk);
            wait_cycles++;
        end

        if (error_count == 0 && angle_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/rmte_pkg.sv
src/rmte_delay.sv
src/rmte_vec_cordic.sv
src/rmte_rot_cordic.sv
src/rotation_matrix_to_euler_angles.sv
src/rmte_checker.sv
verif/tb_rotation_matrix_to_euler_angles.sv
